[rtl/core/slpm_pkg.sv]
// ----------------------------------------------------------------------------
// Sound level peak meter package
// Shared widths, reset values, register and class codes, and the class test.
// ----------------------------------------------------------------------------
package slpm_pkg;

  // Converter sample width; the scaling divisor is its full scale 2^W - 1.
  localparam int SAMPLE_W   = 12;
  localparam int WIN_W      = 8;
  localparam int MV_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] MV_FULL    = SAMPLE_W'(3300);

  localparam int AVG_WINDOWS_DEF = 5;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(200);
  localparam logic [MV_W-1:0]  QUIET_RESET  = MV_W'(3);
  localparam logic [MV_W-1:0]  NORMAL_RESET = MV_W'(10);
  localparam logic [MV_W-1:0]  LOUD_RESET   = MV_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SAMPLES,
    CFG_QUIET_LIMIT,
    CFG_NORMAL_LIMIT,
    CFG_LOUD_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LVL_QUIET,
    LVL_NORMAL,
    LVL_LOUD,
    LVL_OBNOXIOUS
  } level_t;

  typedef struct packed {
    logic [MV_W-1:0] quiet;
    logic [MV_W-1:0] normal;
    logic [MV_W-1:0] loud;
  } limits_t;

  // Width of the span accumulator: one sample span per averaged window.
  function automatic int span_width(input int windows);
    return SAMPLE_W + $clog2(windows + 1);
  endfunction

  // Tests run in order so that misordered limits resolve to the first match.
  function automatic level_t classify(input logic [MV_W-1:0] mv, input limits_t lim);
    level_t lvl;
    priority if (mv < lim.quiet) begin
      lvl = LVL_QUIET;
    end else if (mv < lim.normal) begin
      lvl = LVL_NORMAL;
    end else if (mv < lim.loud) begin
      lvl = LVL_LOUD;
    end else begin
      lvl = LVL_OBNOXIOUS;
    end
    return lvl;
  endfunction

endpackage

[rtl/core/slpm_window.sv]
// ----------------------------------------------------------------------------
// Peak-to-peak window tracker
// Registers each sample, folds it into the running extremes and closes
// windows; hands the span total on after the last window of an average.
// ----------------------------------------------------------------------------
module slpm_window import slpm_pkg::*; #(
  parameter int AVG_WINDOWS = AVG_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [WIN_W-1:0]                    window_samples,
  input  logic [SAMPLE_W-1:0]                 sample,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  output logic                                total_valid,
  output logic [span_width(AVG_WINDOWS)-1:0]  total,
  input  logic                                total_ready
);

  localparam int SPAN_W = span_width(AVG_WINDOWS);
  localparam int WD_W   = $clog2(AVG_WINDOWS + 1);

  logic                s0_valid;
  logic [SAMPLE_W-1:0] s0_sample;

  logic [SAMPLE_W-1:0] running_max;
  logic [SAMPLE_W-1:0] running_min;
  logic [WIN_W-1:0]    samples_in_window;
  logic [WD_W-1:0]     windows_done;
  logic [SPAN_W-1:0]   span_total;

  logic [WIN_W-1:0]    limit;
  logic [SAMPLE_W-1:0] running_max_next;
  logic [SAMPLE_W-1:0] running_min_next;
  logic [WIN_W-1:0]    samples_in_window_next;
  logic [WD_W-1:0]     windows_done_next;
  logic [SPAN_W-1:0]   span_total_next;
  logic                window_close;
  logic                emit;
  logic                s0_take;

  always_comb begin
    limit = (window_samples == '0) ? WIN_W'(1) : window_samples;
    running_max_next = (s0_sample > running_max) ? s0_sample : running_max;
    running_min_next = (s0_sample < running_min) ? s0_sample : running_min;
    samples_in_window_next = samples_in_window + WIN_W'(1);
    // A wrapped count also closes, so a lowered length cannot strand a window.
    window_close = (samples_in_window_next == '0) || !(samples_in_window_next < limit);
    span_total_next = span_total + SPAN_W'(running_max_next - running_min_next);
    windows_done_next = windows_done + WD_W'(1);
    emit = window_close && (windows_done_next == WD_W'(AVG_WINDOWS));
  end

  assign s0_take      = s0_valid && (!emit || !total_valid || total_ready);
  assign sample_ready = !s0_valid || s0_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid          <= 1'b0;
      total_valid       <= 1'b0;
      running_max       <= '0;
      running_min       <= FULL_SCALE;
      samples_in_window <= '0;
      windows_done      <= '0;
      span_total        <= '0;
    end else begin
      if (sample_ready) begin
        s0_valid <= sample_valid;
      end
      if (!total_valid || total_ready) begin
        total_valid <= s0_take && emit;
      end
      if (s0_take) begin
        if (!window_close) begin
          running_max       <= running_max_next;
          running_min       <= running_min_next;
          samples_in_window <= samples_in_window_next;
        end else begin
          running_max       <= '0;
          running_min       <= FULL_SCALE;
          samples_in_window <= '0;
          if (emit) begin
            windows_done <= '0;
            span_total   <= '0;
          end else begin
            windows_done <= windows_done_next;
            span_total   <= span_total_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s0_sample <= sample;
    end
    if (s0_take && emit) begin
      total <= span_total_next;
    end
  end

  a_extremes_ordered : assert property (@(posedge clk) disable iff (rst)
    (samples_in_window != '0) |-> (running_max >= running_min))
    else $error("running extremes out of order inside an open window");

  a_windows_below_avg : assert property (@(posedge clk) disable iff (rst)
    windows_done < WD_W'(AVG_WINDOWS))
    else $error("window count reached the averaging length");

  a_restart_after_emit : assert property (@(posedge clk) disable iff (rst)
    (s0_take && emit) |=> (span_total == '0 && windows_done == '0 && total_valid))
    else $error("accumulator did not restart after a total was handed on");

endmodule

[rtl/core/slpm_scale.sv]
// ----------------------------------------------------------------------------
// Span averaging and millivolt scaling
// Four register stages: average, scaled product, millivolts, classified beat.
// ----------------------------------------------------------------------------
module slpm_scale import slpm_pkg::*; #(
  parameter int AVG_WINDOWS = AVG_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  limits_t                             limits,
  input  logic                                total_valid,
  input  logic [span_width(AVG_WINDOWS)-1:0]  total,
  output logic                                total_ready,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [1:0]                          level_class,
  output logic [MV_W-1:0]                     millivolts,
  output logic [SAMPLE_W-1:0]                 average_span
);

  localparam int SPAN_W    = span_width(AVG_WINDOWS);
  // Rounded-up reciprocal; the error times the largest total stays below 2^shift.
  localparam int DIV_SHIFT = SPAN_W + 3;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + AVG_WINDOWS - 1) / AVG_WINDOWS);
  localparam int PROD_W    = 2 * SAMPLE_W;

  logic                    avg_valid;
  logic [SAMPLE_W-1:0]     avg;
  logic                    prod_valid;
  logic [PROD_W-1:0]       prod;
  logic [SAMPLE_W-1:0]     prod_avg;
  logic                    mv_valid;
  logic [MV_W-1:0]         mv;
  logic [SAMPLE_W-1:0]     mv_avg;

  logic [SPAN_W+RECIP_W-1:0] quot_full;
  logic [SAMPLE_W-1:0]       avg_next;
  logic [PROD_W-1:0]         prod_next;
  logic [SAMPLE_W-1:0]       prod_high;
  logic [SAMPLE_W:0]         prod_rem;
  logic [MV_W-1:0]           mv_next;

  logic res_free;
  logic mv_ready;
  logic prod_ready;
  logic avg_ready;

  assign res_free    = !result_valid || result_ready;
  assign mv_ready    = !mv_valid || res_free;
  assign prod_ready  = !prod_valid || mv_ready;
  assign avg_ready   = !avg_valid || prod_ready;
  assign total_ready = avg_ready;

  always_comb begin
    quot_full = {{RECIP_W{1'b0}}, total} * {{SPAN_W{1'b0}}, RECIP};
    avg_next  = quot_full[DIV_SHIFT +: SAMPLE_W];
    prod_next = {{SAMPLE_W{1'b0}}, avg} * {{SAMPLE_W{1'b0}}, MV_FULL};
    // Division by 2^W - 1: high part plus one correction, since the
    // remainder estimate stays below twice the divisor.
    prod_high = prod[PROD_W-1:SAMPLE_W];
    prod_rem  = {1'b0, prod[SAMPLE_W-1:0]} + {1'b0, prod_high};
    mv_next   = MV_W'(prod_high) + MV_W'(prod_rem >= {1'b0, FULL_SCALE});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid    <= 1'b0;
      prod_valid   <= 1'b0;
      mv_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (avg_ready) begin
        avg_valid <= total_valid;
      end
      if (prod_ready) begin
        prod_valid <= avg_valid;
      end
      if (mv_ready) begin
        mv_valid <= prod_valid;
      end
      if (res_free) begin
        result_valid <= mv_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (avg_ready && total_valid) begin
      avg <= avg_next;
    end
    if (prod_ready && avg_valid) begin
      prod     <= prod_next;
      prod_avg <= avg;
    end
    if (mv_ready && prod_valid) begin
      mv     <= mv_next;
      mv_avg <= prod_avg;
    end
    if (res_free && mv_valid) begin
      level_class  <= classify(mv, limits);
      millivolts   <= mv;
      average_span <= mv_avg;
    end
  end

  a_mv_in_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (millivolts <= MV_FULL))
    else $error("millivolt result above full scale");

  a_quiet_below_limit : assert property (@(posedge clk) disable iff (rst)
    (result_valid && level_class == LVL_QUIET) |-> (millivolts < limits.quiet))
    else $error("quiet class given at or above the quiet limit");

  a_stage_moves : assert property (@(posedge clk) disable iff (rst)
    (mv_valid && res_free) |=> result_valid)
    else $error("scaled value lost between the last two stages");

endmodule

[rtl/core/sound_level_peak_meter.sv]
// ----------------------------------------------------------------------------
// Sound level peak meter
// Peak-to-peak envelope meter with averaged span, millivolt scale and class.
// ----------------------------------------------------------------------------
// The meter takes one 12-bit unsigned converter sample per beat and accepts a
// new beat in every clock cycle, unless a sample closing an average meets a
// full scaler. Each sample updates a running maximum and minimum; after
// window_samples samples (0 acts as 1) the window's span is added to a total,
// and after AVG_WINDOWS windows one result beat carries the average span, that
// span scaled to millivolts (times 3300, divided by 4095, truncated) and a
// loudness class from the three millivolt limits, tested quiet, normal, loud in
// that order. A result becomes valid once the sample that closes its last
// window has been accepted and has passed one input register, the window
// register and four scaling stages (averaging multiply, millivolt multiply,
// divide by full scale, classification), each stage stalling only when the
// one after it is full. Configuration writes take effect on the next clock
// edge and should be made while no sample is in flight.
// ----------------------------------------------------------------------------
module sound_level_peak_meter import slpm_pkg::*; #(
  parameter int AVG_WINDOWS = AVG_WINDOWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  output logic [1:0]            level_class,
  output logic [MV_W-1:0]       millivolts,
  output logic [SAMPLE_W-1:0]   average_span,
  output logic                  result_valid,
  input  logic                  result_ready
);

  localparam int SPAN_W = span_width(AVG_WINDOWS);

  // Configuration registers.
  logic [WIN_W-1:0] window_samples;
  limits_t          limits;

  // Span total beat between the window tracker and the scaler.
  logic              total_valid;
  logic [SPAN_W-1:0] total;
  logic              total_ready;

  // All four indexes name a register, so every write lands somewhere.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= WINDOW_RESET;
      limits.quiet   <= QUIET_RESET;
      limits.normal  <= NORMAL_RESET;
      limits.loud    <= LOUD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_SAMPLES: window_samples <= cfg_data[WIN_W-1:0];
        CFG_QUIET_LIMIT:    limits.quiet   <= cfg_data[MV_W-1:0];
        CFG_NORMAL_LIMIT:   limits.normal  <= cfg_data[MV_W-1:0];
        CFG_LOUD_LIMIT:     limits.loud    <= cfg_data[MV_W-1:0];
      endcase
    end
  end

  // Window tracking: extremes, sample and window counts, span total.
  slpm_window #(
    .AVG_WINDOWS (AVG_WINDOWS)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .window_samples (window_samples),
    .sample         (sample),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .total_valid    (total_valid),
    .total          (total),
    .total_ready    (total_ready)
  );

  // Averaging, millivolt scaling and classification into the result register.
  slpm_scale #(
    .AVG_WINDOWS (AVG_WINDOWS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .limits       (limits),
    .total_valid  (total_valid),
    .total        (total),
    .total_ready  (total_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .level_class  (level_class),
    .millivolts   (millivolts),
    .average_span (average_span)
  );

endmodule
